// ----- design/u8v_pkg.sv -----
// Shared types, constants and helpers for the UTF-8 stream validator.
package u8v_pkg;

	localparam int ByteW  = 8;
	localparam int CountW = 3;
	localparam int CodeW  = 31;

	// Code point limits
	localparam logic [CodeW-1:0] CodeLimit   = 31'h0011_0000;
	localparam logic [CodeW-1:0] CodeNonChar = 31'h0000_FFFE;
	localparam logic [CodeW-1:0] SurrogateLo = 31'h0000_D800;
	localparam logic [CodeW-1:0] SurrogateHi = 31'h0000_DFFF;

	// Lead byte thresholds
	localparam logic [ByteW-1:0] LeadSix   = 8'hFC;
	localparam logic [ByteW-1:0] LeadFive  = 8'hF8;
	localparam logic [ByteW-1:0] LeadFour  = 8'hF0;
	localparam logic [ByteW-1:0] LeadThree = 8'hE0;
	localparam logic [ByteW-1:0] LeadBad   = 8'hFE;

	// Scanner state carried from one byte to the next
	typedef struct packed {
		logic              err;
		logic [CountW-1:0] rem;
		logic [CountW-1:0] len;
		logic [CodeW-1:0]  acc;
	} scan_state_t;

	// Smallest code point that a sequence of the given length may encode
	function automatic logic [CodeW-1:0] least_code(input logic [CountW-1:0] len);
		logic [CodeW-1:0] least;
		case (len)
			3'd2:    least = 31'h0000_0080;
			3'd3:    least = 31'h0000_0800;
			3'd4:    least = 31'h0001_0000;
			3'd5:    least = 31'h0020_0000;
			3'd6:    least = 31'h0400_0000;
			default: least = '0;
		endcase
		return least;
	endfunction

	// Continuation byte has the form 10xxxxxx
	function automatic logic is_cont(input logic [ByteW-1:0] b);
		return b[7:6] == 2'b10;
	endfunction

endpackage

// ----- design/utf8_stream_validator_core.sv -----
// Top level of the UTF-8 stream validator: input register, scanner state, result register.
//
// Usage: feed a zero-terminated string one byte per request on the input
// channel (in_valid, in_ready, data_byte). Every non-zero byte updates the
// scanner state and gives no result. A zero byte ends the string and gives
// one result request on the output channel (out_valid, out_ready,
// string_valid): 1 if the string was valid UTF-8, 0 otherwise. The zero
// byte also clears the scanner for the next string.
// Result path: an accepted zero byte first waits in the input register, then
// its verdict is loaded into the result register, where it is held until
// it is taken.
// Throughput: one byte per cycle unless a zero byte stalls (see Stall); the
// scanner update between input register and scanner/result registers is combinational.
// Reset (arst_n low) clears the scanner, the input valid flag and the result
// register; no request is pending afterwards.
// Stall: while a result waits and out_ready is low, non-zero bytes keep
// flowing; a following zero byte holds in the input register, and in_ready
// drops only while it waits there.
module utf8_stream_validator_core import u8v_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ByteW-1:0] data_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             string_valid
);

	logic             valid_s1;
	logic [ByteW-1:0] data_s1;
	scan_state_t      state_q;
	scan_state_t      state_d;
	logic             out_valid_q;
	logic             string_valid_q;
	logic             end_s1;
	logic             out_free;
	logic             adv_s1;
	logic             in_fire;

	// Handshake control
	assign end_s1   = data_s1 == '0;
	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && (!end_s1 || out_free);
	assign in_ready = !valid_s1 || adv_s1;
	assign in_fire  = in_valid && in_ready;

	// Capture the incoming byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1 <= data_byte;
		end
	end

	u8v_step u_step (
		.cur       (state_q),
		.data_byte (data_s1),
		.nxt       (state_d)
	);

	// Advance the scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_d;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			string_valid_q <= 1'b0;
		end else if (adv_s1 && end_s1) begin
			out_valid_q    <= 1'b1;
			string_valid_q <= !state_q.err && (state_q.rem == '0);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign string_valid = string_valid_q;

	// A zero byte clears the scanner and raises a result
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && end_s1) |=> (state_q == '0) && out_valid_q)
		else $error("zero byte did not clear scanner or raise result");

	// No more than five continuation bytes are ever outstanding
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.rem <= 3'd5)
		else $error("continuation count out of range");

	// Sequence length is tracked exactly while a sequence is open
	a_len_track: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q.rem == '0) == (state_q.len == '0)) &&
		((state_q.rem == '0) || (state_q.rem < state_q.len)))
		else $error("sequence length and count disagree");

	// A waiting result is not overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(adv_s1 && end_s1))
		else $error("result overwritten while stalled");

endmodule

// ----- design/u8v_step.sv -----
// Next-state logic of the validator for one string byte.
module u8v_step import u8v_pkg::*; (
	input  scan_state_t      cur,
	input  logic [ByteW-1:0] data_byte,
	output scan_state_t      nxt
);

	logic [CodeW-1:0] acc_new;
	logic             code_bad;

	// Shift in six payload bits and check the finished code point
	always_comb begin
		acc_new  = {cur.acc[CodeW-7:0], data_byte[5:0]};
		code_bad = (acc_new < least_code(cur.len)) || (acc_new >= CodeLimit) ||
			(acc_new == CodeNonChar) ||
			((acc_new >= SurrogateLo) && (acc_new <= SurrogateHi));
	end

	// Advance the scanner
	always_comb begin
		nxt = cur;
		if (data_byte == '0) begin
			nxt = '0;
		end else if (cur.err) begin
			nxt = cur;
		end else if (cur.rem == '0) begin
			if (!data_byte[7]) begin
				nxt = cur;
			end else if (is_cont(data_byte) || data_byte >= LeadBad) begin
				nxt.err = 1'b1;
			end else if (data_byte >= LeadSix) begin
				nxt.len = 3'd6;
				nxt.rem = 3'd5;
				nxt.acc = CodeW'(data_byte[0]);
			end else if (data_byte >= LeadFive) begin
				nxt.len = 3'd5;
				nxt.rem = 3'd4;
				nxt.acc = CodeW'(data_byte[1:0]);
			end else if (data_byte >= LeadFour) begin
				nxt.len = 3'd4;
				nxt.rem = 3'd3;
				nxt.acc = CodeW'(data_byte[2:0]);
			end else if (data_byte >= LeadThree) begin
				nxt.len = 3'd3;
				nxt.rem = 3'd2;
				nxt.acc = CodeW'(data_byte[3:0]);
			end else begin
				nxt.len = 3'd2;
				nxt.rem = 3'd1;
				nxt.acc = CodeW'(data_byte[4:0]);
			end
		end else if (!is_cont(data_byte)) begin
			nxt.err = 1'b1;
		end else if (cur.rem == 3'd1) begin
			nxt.err = code_bad;
			nxt.rem = '0;
			nxt.len = '0;
			nxt.acc = '0;
		end else begin
			nxt.rem = cur.rem - 3'd1;
			nxt.acc = acc_new;
		end
	end

endmodule
